/* hdl/mnep_pkg.sv */
package mnep_pkg;

  // field widths
  localparam int CHAR_W    = 8;
  localparam int NUM_W     = 16;
  localparam int DUR_BITS  = 32;
  localparam int SR_W      = 18;
  localparam int TEMPO_W   = 10;
  localparam int VOL_W     = 8;
  localparam int DECAY_W   = 16;
  localparam int NOTE_W    = 7;
  localparam int LEN_W     = 7;
  localparam int OCT_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 18;
  localparam int OUT_DAT_W = 64;

  // divider operand widths: sample rate times 240 and tempo times length
  localparam int DIV_NUM_W = SR_W + 8;
  localparam int DIV_DEN_W = TEMPO_W + NUM_W;

  // parameter defaults
  localparam int DURATION_WIDTH_DEF = 32;
  localparam int FIFO_DEPTH_DEF     = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TEMPO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_VOLUME = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE   = 2'd3;

  // configuration reset values
  localparam logic [SR_W-1:0]    RST_SAMPLE_RATE  = 18'd48000;
  localparam logic [TEMPO_W-1:0] RST_START_TEMPO  = 10'd120;
  localparam logic [VOL_W-1:0]   RST_START_VOLUME = 8'd100;
  localparam logic [DECAY_W-1:0] RST_DECAY_RATE   = 16'd32768;

  // command codes, letters a..g are 1..7
  localparam logic [3:0] CMD_NONE = 4'd0;
  localparam logic [3:0] CMD_A    = 4'd1;
  localparam logic [3:0] CMD_G    = 4'd7;
  localparam logic [3:0] CMD_N    = 4'd8;
  localparam logic [3:0] CMD_R    = 4'd9;
  localparam logic [3:0] CMD_O    = 4'd10;
  localparam logic [3:0] CMD_L    = 4'd11;
  localparam logic [3:0] CMD_T    = 4'd12;
  localparam logic [3:0] CMD_V    = 4'd13;
  localparam logic [3:0] CMD_AT   = 4'd14;

  // accidental codes
  localparam logic [1:0] ACC_NAT   = 2'd0;
  localparam logic [1:0] ACC_SHARP = 2'd1;
  localparam logic [1:0] ACC_FLAT  = 2'd2;

  // character classes from the front
  localparam logic [3:0] CLS_OTHER = 4'd0;
  localparam logic [3:0] CLS_DIGIT = 4'd1;
  localparam logic [3:0] CLS_ACC   = 4'd2;
  localparam logic [3:0] CLS_DOT   = 4'd3;
  localparam logic [3:0] CLS_TIE   = 4'd4;
  localparam logic [3:0] CLS_UP    = 4'd5;
  localparam logic [3:0] CLS_DN    = 4'd6;
  localparam logic [3:0] CLS_NOTE  = 4'd7;
  localparam logic [3:0] CLS_CMD   = 4'd8;
  localparam logic [3:0] CLS_SKIP  = 4'd9;

  // classified character handed from front to back
  typedef struct packed {
    logic [3:0] cls;
    logic [3:0] code;
    logic       eot;
    logic       init;
    logic       pre_l;
  } token_t;

  // semitone above c for letters a..g
  function automatic logic [3:0] letter_semis(input logic [3:0] code);
    logic [3:0] s;
    case (code)
      4'd1: s = 4'd9;
      4'd2: s = 4'd11;
      4'd3: s = 4'd0;
      4'd4: s = 4'd2;
      4'd5: s = 4'd4;
      4'd6: s = 4'd5;
      4'd7: s = 4'd7;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

/* hdl/mnep_front.sv */
module mnep_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [mnep_pkg::CHAR_W-1:0] in_tdata,
  input  logic                        in_tlast,
  input  logic                        q_full,
  output logic                        q_push,
  output mnep_pkg::token_t            q_tok
);

  localparam logic [2:0] PREFIX_DONE = 3'd4;

  logic [2:0]                  prog_r, prog_nxt;
  logic [mnep_pkg::CHAR_W-1:0] c_lo;
  logic [mnep_pkg::CHAR_W-1:0] pfx_char;
  logic                        pfx_match;
  logic [3:0]                  cls, code;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // expected byte of the leading "MML@"
  always_comb begin
    case (prog_r[1:0])
      2'd0:    pfx_char = 8'h4D;
      2'd1:    pfx_char = 8'h4D;
      2'd2:    pfx_char = 8'h4C;
      default: pfx_char = 8'h40;
    endcase
  end

  assign pfx_match = (prog_r != PREFIX_DONE) && (in_tdata == pfx_char);

  // fold upper case letters
  assign c_lo = (in_tdata >= 8'h41 && in_tdata <= 8'h5A) ? in_tdata + 8'd32 : in_tdata;

  // classify the byte
  always_comb begin
    cls  = mnep_pkg::CLS_OTHER;
    code = mnep_pkg::CMD_NONE;
    if (c_lo >= 8'h30 && c_lo <= 8'h39) begin
      cls  = mnep_pkg::CLS_DIGIT;
      code = 4'(c_lo - 8'h30);
    end else if (c_lo >= 8'h61 && c_lo <= 8'h67) begin
      cls  = mnep_pkg::CLS_NOTE;
      code = 4'(c_lo - 8'h60);
    end else begin
      case (c_lo)
        8'h2B, 8'h23: begin
          cls  = mnep_pkg::CLS_ACC;
          code = {2'b00, mnep_pkg::ACC_SHARP};
        end
        8'h2D: begin
          cls  = mnep_pkg::CLS_ACC;
          code = {2'b00, mnep_pkg::ACC_FLAT};
        end
        8'h2E: cls = mnep_pkg::CLS_DOT;
        8'h26: cls = mnep_pkg::CLS_TIE;
        8'h3E: cls = mnep_pkg::CLS_UP;
        8'h3C: cls = mnep_pkg::CLS_DN;
        8'h6E: begin
          cls  = mnep_pkg::CLS_NOTE;
          code = mnep_pkg::CMD_N;
        end
        8'h72: begin
          cls  = mnep_pkg::CLS_NOTE;
          code = mnep_pkg::CMD_R;
        end
        8'h6F: begin
          cls  = mnep_pkg::CLS_CMD;
          code = mnep_pkg::CMD_O;
        end
        8'h6C: begin
          cls  = mnep_pkg::CLS_CMD;
          code = mnep_pkg::CMD_L;
        end
        8'h74: begin
          cls  = mnep_pkg::CLS_CMD;
          code = mnep_pkg::CMD_T;
        end
        8'h76: begin
          cls  = mnep_pkg::CLS_CMD;
          code = mnep_pkg::CMD_V;
        end
        8'h40: begin
          cls  = mnep_pkg::CLS_CMD;
          code = mnep_pkg::CMD_AT;
        end
        default: cls = mnep_pkg::CLS_OTHER;
      endcase
    end
  end

  // token assembly
  always_comb begin
    q_tok.cls   = pfx_match ? mnep_pkg::CLS_SKIP : cls;
    q_tok.code  = code;
    q_tok.eot   = in_tlast;
    q_tok.init  = (prog_r == 3'd0);
    q_tok.pre_l = !pfx_match && (prog_r == 3'd3);
  end

  // prefix progress
  always_comb begin
    prog_nxt = prog_r;
    if (q_push) begin
      if (in_tlast) begin
        prog_nxt = 3'd0;
      end else if (pfx_match) begin
        prog_nxt = prog_r + 3'd1;
      end else begin
        prog_nxt = PREFIX_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_r <= 3'd0;
    end else begin
      prog_r <= prog_nxt;
    end
  end

endmodule

/* hdl/mnep_fifo.sv */
module mnep_fifo #(
  parameter int DEPTH = mnep_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mnep_pkg::token_t push_tok,
  output logic             full,
  input  logic             pop,
  output mnep_pkg::token_t pop_tok,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mnep_pkg::token_t   mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_r, rd_r;
  logic [CNT_W-1:0]   cnt_r;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_tok = mem_r[rd_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_tok;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

/* hdl/mnep_div.sv */
module mnep_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [mnep_pkg::DIV_NUM_W-1:0] num,
  input  logic [mnep_pkg::DIV_DEN_W-1:0] den,
  output logic                           done,
  output logic [mnep_pkg::DIV_NUM_W-1:0] quo
);

  localparam int NW    = mnep_pkg::DIV_NUM_W;
  localparam int DW    = mnep_pkg::DIV_DEN_W;
  localparam int CNT_W = $clog2(NW);

  logic [NW-1:0]    quo_r;
  logic [DW:0]      rem_r;
  logic [DW-1:0]    den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DW:0]      trial;
  logic             ge;

  assign trial = {rem_r[DW-1:0], quo_r[NW-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign done  = done_r;
  assign quo   = quo_r;

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], ge};
      rem_r <= ge ? trial - {1'b0, den_r} : trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/mnep_back.sv */
module mnep_back #(
  parameter int DURATION_WIDTH = mnep_pkg::DURATION_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  input  mnep_pkg::token_t               q_tok,
  output logic                           q_pop,
  input  logic [mnep_pkg::SR_W-1:0]      smp_rate,
  input  logic [mnep_pkg::TEMPO_W-1:0]   start_tempo,
  input  logic [mnep_pkg::VOL_W-1:0]     start_volume,
  input  logic [mnep_pkg::DECAY_W-1:0]   decay_cfg,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mnep_pkg::OUT_DAT_W-1:0] out_tdata,
  output logic                           out_tlast
);

  localparam int DB    = mnep_pkg::DUR_BITS;
  localparam int CAP_W = (DURATION_WIDTH > DB) ? DB : DURATION_WIDTH;
  localparam logic [DB:0] DUR_CAP = (33'd1 << CAP_W) - 33'd1;
  localparam int DNW   = mnep_pkg::DIV_NUM_W;
  localparam int DDW   = mnep_pkg::DIV_DEN_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_START  = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_HOLD   = 3'd4;
  localparam logic [2:0] ST_ACT    = 3'd5;
  localparam logic [2:0] ST_END    = 3'd6;
  localparam logic [2:0] ST_FLUSH  = 3'd7;

  // parse modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_PEND = 2'd1;
  localparam logic [1:0] MODE_DOTS = 2'd2;

  // actions after a command is finished
  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_DOT  = 3'd1;
  localparam logic [2:0] ACT_TIE  = 3'd2;
  localparam logic [2:0] ACT_UP   = 3'd3;
  localparam logic [2:0] ACT_DN   = 3'd4;
  localparam logic [2:0] ACT_NOTE = 3'd5;
  localparam logic [2:0] ACT_CMD  = 3'd6;

  localparam logic [mnep_pkg::OCT_W-1:0] OCT_MAX = 4'd15;

  logic [2:0]                         state_r, state_nxt;
  mnep_pkg::token_t                   tok_r, tok_nxt;
  logic [2:0]                         act_r, act_nxt;
  logic                               eotph_r, eotph_nxt;
  logic [1:0]                         mode_r, mode_nxt;
  logic [3:0]                         cmd_r, cmd_nxt;
  logic [mnep_pkg::NUM_W-1:0]         num_r, num_nxt;
  logic                               pres_r, pres_nxt;
  logic [1:0]                         acc_r, acc_nxt;
  logic [mnep_pkg::OCT_W-1:0]         oct_r, oct_nxt;
  logic [mnep_pkg::LEN_W-1:0]         dlen_r, dlen_nxt;
  logic [mnep_pkg::TEMPO_W-1:0]       tempo_r, tempo_nxt;
  logic [mnep_pkg::VOL_W-1:0]         vol_r, vol_nxt;
  logic                               tie_r, tie_nxt;
  logic [DB-1:0]                      dot_r, dot_nxt;
  logic                               hv_r, hv_nxt;
  logic [mnep_pkg::NOTE_W-1:0]        hnote_r, hnote_nxt;
  logic                               hrest_r, hrest_nxt;
  logic [DB-1:0]                      hdur_r, hdur_nxt;
  logic [mnep_pkg::VOL_W-1:0]         hvol_r, hvol_nxt;

  logic                               ov_r;
  logic [mnep_pkg::OUT_DAT_W-1:0]     od_r;
  logic                               ol_r;
  logic                               out_free, emit, emit_last;

  logic                               notelike, is_letter, do_commit;
  logic [2:0]                         commit_next;
  logic [mnep_pkg::NUM_W-1:0]         len;
  logic [19:0]                        num_acc;
  logic                               div_start, div_done;
  logic [DNW-1:0]                     div_num;
  logic [DDW-1:0]                     div_den;
  logic [mnep_pkg::DIV_NUM_W-1:0]     div_quo;
  logic [DB-1:0]                      dur;
  logic [7:0]                         nbase, nsharp, nfin;
  logic [mnep_pkg::NOTE_W-1:0]        note;
  logic [DB:0]                        tie_sum, dot_sum;

  assign notelike  = (cmd_r >= mnep_pkg::CMD_A) && (cmd_r <= mnep_pkg::CMD_R);
  assign is_letter = (cmd_r >= mnep_pkg::CMD_A) && (cmd_r <= mnep_pkg::CMD_G);
  assign out_free  = !ov_r || out_tready;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;

  // note length in use
  assign len = (cmd_r != mnep_pkg::CMD_N && pres_r && num_r != '0)
             ? num_r : mnep_pkg::NUM_W'(dlen_r);

  // operands registered inside the divider
  assign div_start = (state_r == ST_START);
  assign div_num   = DNW'(smp_rate) * DNW'(240);
  assign div_den   = DDW'(tempo_r) * DDW'(len);

  mnep_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // duration clipped to the configured width
  assign dur = ({7'd0, div_quo} > DUR_CAP) ? DUR_CAP[DB-1:0] : DB'(div_quo);

  // pitch from octave, letter and accidental
  assign nbase  = 8'(oct_r * 8'd12) + 8'(mnep_pkg::letter_semis(cmd_r)) + 8'd12;
  assign nsharp = (acc_r == mnep_pkg::ACC_SHARP) ? nbase + 8'd1 : nbase;
  assign nfin   = (acc_r == mnep_pkg::ACC_FLAT)
                ? ((nbase == 8'd0) ? 8'd0 : nbase - 8'd1) : nsharp;
  always_comb begin
    if (cmd_r == mnep_pkg::CMD_N) begin
      note = (num_r > 16'd127) ? 7'd127 : num_r[6:0];
    end else begin
      note = (nfin > 8'd127) ? 7'd127 : nfin[6:0];
    end
  end

  // saturating duration sums
  assign tie_sum = {1'b0, hdur_r} + {1'b0, dur};
  assign dot_sum = {1'b0, hdur_r} + {1'b0, dot_r};
  assign num_acc = 20'(num_r) * 20'd10 + 20'(tok_r.code);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    tok_nxt     = tok_r;
    act_nxt     = act_r;
    eotph_nxt   = eotph_r;
    mode_nxt    = mode_r;
    cmd_nxt     = cmd_r;
    num_nxt     = num_r;
    pres_nxt    = pres_r;
    acc_nxt     = acc_r;
    oct_nxt     = oct_r;
    dlen_nxt    = dlen_r;
    tempo_nxt   = tempo_r;
    vol_nxt     = vol_r;
    tie_nxt     = tie_r;
    dot_nxt     = dot_r;
    hv_nxt      = hv_r;
    hnote_nxt   = hnote_r;
    hrest_nxt   = hrest_r;
    hdur_nxt    = hdur_r;
    hvol_nxt    = hvol_r;
    emit        = 1'b0;
    emit_last   = 1'b0;
    do_commit   = 1'b0;
    commit_next = ST_ACT;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          tok_nxt   = q_tok;
          eotph_nxt = 1'b0;
          state_nxt = (q_tok.cls == mnep_pkg::CLS_SKIP) ? ST_END : ST_DECODE;
          // fresh text state
          if (q_tok.init) begin
            mode_nxt  = MODE_IDLE;
            cmd_nxt   = mnep_pkg::CMD_NONE;
            num_nxt   = '0;
            pres_nxt  = 1'b0;
            acc_nxt   = mnep_pkg::ACC_NAT;
            oct_nxt   = 4'd4;
            dlen_nxt  = 7'd4;
            tempo_nxt = (start_tempo == '0) ? 10'd1 : start_tempo;
            vol_nxt   = start_volume;
            tie_nxt   = 1'b0;
            dot_nxt   = '0;
            hv_nxt    = 1'b0;
            hnote_nxt = '0;
            hrest_nxt = 1'b0;
            hdur_nxt  = '0;
            hvol_nxt  = '0;
          end
          // "MML" without '@' leaves an l command open
          if (q_tok.pre_l) begin
            mode_nxt = MODE_PEND;
            cmd_nxt  = mnep_pkg::CMD_L;
            num_nxt  = '0;
            pres_nxt = 1'b0;
            acc_nxt  = mnep_pkg::ACC_NAT;
          end
        end
      end

      ST_DECODE: begin
        state_nxt = ST_ACT;
        act_nxt   = ACT_NONE;
        do_commit = (mode_r == MODE_PEND);
        mode_nxt  = MODE_IDLE;
        case (tok_r.cls)
          mnep_pkg::CLS_DIGIT: begin
            if (mode_r == MODE_PEND) begin
              do_commit = 1'b0;
              mode_nxt  = mode_r;
              num_nxt   = (num_acc > 20'd65535) ? 16'hFFFF : num_acc[15:0];
              pres_nxt  = 1'b1;
              state_nxt = ST_END;
            end
          end
          mnep_pkg::CLS_ACC: begin
            if (mode_r == MODE_PEND && is_letter && !pres_r) begin
              do_commit = 1'b0;
              mode_nxt  = mode_r;
              acc_nxt   = tok_r.code[1:0];
              state_nxt = ST_END;
            end
          end
          mnep_pkg::CLS_DOT: begin
            if (mode_r == MODE_PEND && notelike) begin
              act_nxt = ACT_DOT;
            end else if (mode_r == MODE_DOTS) begin
              act_nxt = ACT_DOT;
            end
          end
          mnep_pkg::CLS_TIE:  act_nxt = ACT_TIE;
          mnep_pkg::CLS_UP:   act_nxt = ACT_UP;
          mnep_pkg::CLS_DN:   act_nxt = ACT_DN;
          mnep_pkg::CLS_NOTE: act_nxt = ACT_NOTE;
          mnep_pkg::CLS_CMD:  act_nxt = ACT_CMD;
          default:            act_nxt = ACT_NONE;
        endcase
      end

      ST_START: state_nxt = ST_DIV;

      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_HOLD;
        end
      end

      // note or rest is committed with its duration
      ST_HOLD: begin
        if (tie_r && hv_r) begin
          hdur_nxt = (tie_sum > DUR_CAP) ? DUR_CAP[DB-1:0] : tie_sum[DB-1:0];
        end else begin
          hv_nxt    = 1'b1;
          hrest_nxt = (cmd_r == mnep_pkg::CMD_R);
          hnote_nxt = (cmd_r == mnep_pkg::CMD_R) ? '0 : note;
          hdur_nxt  = dur;
          hvol_nxt  = vol_r;
        end
        tie_nxt   = 1'b0;
        dot_nxt   = dur >> 1;
        num_nxt   = '0;
        pres_nxt  = 1'b0;
        acc_nxt   = mnep_pkg::ACC_NAT;
        mode_nxt  = MODE_IDLE;
        state_nxt = eotph_r ? ST_FLUSH : ST_ACT;
      end

      ST_ACT: begin
        state_nxt = ST_END;
        case (act_r)
          ACT_TIE: tie_nxt = 1'b1;
          ACT_UP: begin
            if (oct_r < OCT_MAX) begin
              oct_nxt = oct_r + 4'd1;
            end
          end
          ACT_DN: begin
            if (oct_r != '0) begin
              oct_nxt = oct_r - 4'd1;
            end
          end
          ACT_DOT: begin
            mode_nxt = MODE_DOTS;
            hdur_nxt = (dot_sum > DUR_CAP) ? DUR_CAP[DB-1:0] : dot_sum[DB-1:0];
            dot_nxt  = dot_r >> 1;
          end
          ACT_NOTE: begin
            if (hv_r && !tie_r) begin
              if (out_free) begin
                emit      = 1'b1;
                emit_last = !tok_r.eot;
                hv_nxt    = 1'b0;
              end else begin
                state_nxt = ST_ACT;
              end
            end
            if (state_nxt == ST_END) begin
              mode_nxt = MODE_PEND;
              cmd_nxt  = tok_r.code;
              num_nxt  = '0;
              pres_nxt = 1'b0;
              acc_nxt  = mnep_pkg::ACC_NAT;
            end
          end
          ACT_CMD: begin
            mode_nxt = MODE_PEND;
            cmd_nxt  = tok_r.code;
            num_nxt  = '0;
            pres_nxt = 1'b0;
            acc_nxt  = mnep_pkg::ACC_NAT;
          end
          default: state_nxt = ST_END;
        endcase
      end

      ST_END: begin
        if (!tok_r.eot) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt   = ST_FLUSH;
          mode_nxt    = MODE_IDLE;
          eotph_nxt   = 1'b1;
          do_commit   = (mode_r == MODE_PEND);
          commit_next = ST_FLUSH;
        end
      end

      // end of text: send the held event
      ST_FLUSH: begin
        if (hv_r) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_last = 1'b1;
            hv_nxt    = 1'b0;
            tie_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end
        end else begin
          tie_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // finish the open command
    if (do_commit) begin
      if (notelike) begin
        state_nxt = ST_START;
      end else begin
        case (cmd_r)
          mnep_pkg::CMD_O: begin
            if (pres_r) begin
              oct_nxt = (num_r > 16'd15) ? OCT_MAX : num_r[3:0];
            end
          end
          mnep_pkg::CMD_L: begin
            if (pres_r && num_r != '0) begin
              dlen_nxt = (num_r > 16'd127) ? 7'd127 : num_r[6:0];
            end
          end
          mnep_pkg::CMD_T: begin
            if (pres_r && num_r != '0) begin
              tempo_nxt = (num_r > 16'd1023) ? 10'd1023 : num_r[9:0];
            end
          end
          mnep_pkg::CMD_V: begin
            if (pres_r) begin
              vol_nxt = (num_r > 16'd255) ? 8'd255 : num_r[7:0];
            end
          end
          default: vol_nxt = vol_r;
        endcase
        num_nxt   = '0;
        pres_nxt  = 1'b0;
        acc_nxt   = mnep_pkg::ACC_NAT;
        state_nxt = commit_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      act_r   <= ACT_NONE;
      eotph_r <= 1'b0;
      mode_r  <= MODE_IDLE;
      cmd_r   <= mnep_pkg::CMD_NONE;
      num_r   <= '0;
      pres_r  <= 1'b0;
      acc_r   <= mnep_pkg::ACC_NAT;
      oct_r   <= 4'd4;
      dlen_r  <= 7'd4;
      tempo_r <= mnep_pkg::RST_START_TEMPO;
      vol_r   <= mnep_pkg::RST_START_VOLUME;
      tie_r   <= 1'b0;
      dot_r   <= '0;
      hv_r    <= 1'b0;
      hnote_r <= '0;
      hrest_r <= 1'b0;
      hdur_r  <= '0;
      hvol_r  <= '0;
    end else begin
      state_r <= state_nxt;
      act_r   <= act_nxt;
      eotph_r <= eotph_nxt;
      mode_r  <= mode_nxt;
      cmd_r   <= cmd_nxt;
      num_r   <= num_nxt;
      pres_r  <= pres_nxt;
      acc_r   <= acc_nxt;
      oct_r   <= oct_nxt;
      dlen_r  <= dlen_nxt;
      tempo_r <= tempo_nxt;
      vol_r   <= vol_nxt;
      tie_r   <= tie_nxt;
      dot_r   <= dot_nxt;
      hv_r    <= hv_nxt;
      hnote_r <= hnote_nxt;
      hrest_r <= hrest_nxt;
      hdur_r  <= hdur_nxt;
      hvol_r  <= hvol_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (emit) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      od_r <= {decay_cfg, hvol_r, hdur_r, hrest_r, hnote_r};
      ol_r <= emit_last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

`ifndef SYNTHESIS
  a_pop_decode: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_DECODE || state_r == ST_END))
    else $error("popped token not decoded");
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    dlen_r != '0)
    else $error("default length is zero");
  a_tempo_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    tempo_r != '0)
    else $error("tempo is zero");
  a_dur_cap: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, hdur_r} <= DUR_CAP)
    else $error("held duration beyond cap");
  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_done) |=> state_r == ST_HOLD)
    else $error("quotient not taken");
`endif

endmodule

/* hdl/mml_note_event_parser.sv */
// MML note event parser
// in_*: one text byte per transfer in in_tdata, in_tlast set on the final byte
//   of a text. out_*: one note or rest event per transfer, out_tlast set on
//   the last event caused by an input byte. cfg_*: register writes, always
//   ready, index 0 sample rate, 1 start tempo, 2 start volume, 3 decay rate.
// A front stage classifies bytes and strips a leading "MML@"; a token queue
// feeds the back sequencer, which parses commands and holds one event.
// The back takes one byte at a time; a byte that finishes a note or rest
// runs the 26-step restoring divider for its duration, and an end-of-text
// byte may run it twice. The input keeps being taken while the queue has
// room. An event appears on out_* in the cycle after it is emitted and stays
// in the output register until taken; a stalled receiver stalls the back
// sequencer only when a second event must leave, and the input once the
// queue fills. Synchronous reset empties the queue and output, restores
// registers to 48000, 120, 100, 32768 and starts a new text.
module mml_note_event_parser #(
  parameter int DURATION_WIDTH = mnep_pkg::DURATION_WIDTH_DEF,
  parameter int FIFO_DEPTH     = mnep_pkg::FIFO_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // text_char
  input  logic [mnep_pkg::CHAR_W-1:0]    in_tdata,
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // note, rest flag, duration in samples, event_volume, event_decay
  output logic [mnep_pkg::OUT_DAT_W-1:0] out_tdata,
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mnep_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mnep_pkg::CFG_DAT_W-1:0] cfg_data
);

  logic [mnep_pkg::SR_W-1:0]    sr_r;
  logic [mnep_pkg::TEMPO_W-1:0] stempo_r;
  logic [mnep_pkg::VOL_W-1:0]   svol_r;
  logic [mnep_pkg::DECAY_W-1:0] decay_r;

  logic             q_full, q_empty, q_push, q_pop;
  mnep_pkg::token_t push_tok, pop_tok;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r     <= mnep_pkg::RST_SAMPLE_RATE;
      stempo_r <= mnep_pkg::RST_START_TEMPO;
      svol_r   <= mnep_pkg::RST_START_VOLUME;
      decay_r  <= mnep_pkg::RST_DECAY_RATE;
    end else if (cfg_valid) begin
      case (cfg_index)
        mnep_pkg::REG_SAMPLE_RATE:  sr_r     <= cfg_data;
        mnep_pkg::REG_START_TEMPO:  stempo_r <= cfg_data[mnep_pkg::TEMPO_W-1:0];
        mnep_pkg::REG_START_VOLUME: svol_r   <= cfg_data[mnep_pkg::VOL_W-1:0];
        mnep_pkg::REG_DECAY_RATE:   decay_r  <= cfg_data[mnep_pkg::DECAY_W-1:0];
        default:                    decay_r  <= decay_r;
      endcase
    end
  end

  mnep_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_tok     (push_tok)
  );

  mnep_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_tok (push_tok),
    .full     (q_full),
    .pop      (q_pop),
    .pop_tok  (pop_tok),
    .empty    (q_empty)
  );

  mnep_back #(
    .DURATION_WIDTH (DURATION_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_tok        (pop_tok),
    .q_pop        (q_pop),
    .smp_rate     (sr_r),
    .start_tempo  (stempo_r),
    .start_volume (svol_r),
    .decay_cfg    (decay_r),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast)
  );

endmodule
